/* sv/lrgs_pkg.sv */
// ----------------------------------------------------------------------------
// lrgs_pkg
// Shared types, codes and fixed widths for the low-rank grid sample lookup.
// ----------------------------------------------------------------------------
package lrgs_pkg;

    localparam int CMD_W       = 3;
    localparam int INDEX_W     = 12;
    localparam int VALUE_IN_W  = 32;
    localparam int COORD_W     = 16;
    localparam int SIZE_W      = 5;
    localparam int RANK_REG_W  = 4;
    localparam int S_TDATA_W   = 96;
    localparam int S_TUSER_W   = CMD_W;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 1;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = SIZE_W;

    localparam int WIDX_LSB = 0;
    localparam int WVAL_LSB = WIDX_LSB + INDEX_W;
    localparam int QX_LSB   = WVAL_LSB + VALUE_IN_W;
    localparam int QY_LSB   = QX_LSB + COORD_W;
    localparam int QZ_LSB   = QY_LSB + COORD_W;

    localparam int DEF_MAX_DIM     = 16;
    localparam int DEF_MAX_RANK    = 8;
    localparam int DEF_VALUE_WIDTH = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_DENSE = 3'd0,
        CMD_WR_LEFT  = 3'd1,
        CMD_WR_SING  = 3'd2,
        CMD_WR_RIGHT = 3'd3,
        CMD_QUERY    = 3'd4
    } cmd_code_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE_SVD  = 3'd0,
        REG_SIZE_X    = 3'd1,
        REG_SIZE_Y    = 3'd2,
        REG_SIZE_Z    = 3'd3,
        REG_RANK_USED = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SRC_ZERO  = 2'd0,
        SRC_DENSE = 2'd1,
        SRC_ACC   = 2'd2
    } result_src_t;

    typedef struct packed {
        logic        accept;
        logic        clamp;
        logic        index;
        logic        dense_rd;
        logic        svd_issue;
        logic        load_out;
        result_src_t src;
    } dp_cmd_t;

    typedef struct packed {
        logic is_query;
        logic empty;
        logic mode_svd;
        logic rank_zero;
        logic last_issue;
        logic pipe_busy;
        logic out_free;
    } dp_stat_t;

endpackage

/* sv/lrgs_ram.sv */
// ----------------------------------------------------------------------------
// lrgs_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module lrgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/lrgs_ctrl.sv */
// ----------------------------------------------------------------------------
// lrgs_ctrl
// Sequencer for one query: clamp, index, then a dense read, or a rank loop
// and drain, or neither; then hand the result to the output register.
// ----------------------------------------------------------------------------
module lrgs_ctrl
    import lrgs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_axis_tvalid,
    output logic     s_axis_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CLAMP  = 7'b0000010,
        ST_INDEX  = 7'b0000100,
        ST_DREAD  = 7'b0001000,
        ST_RUN    = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    result_src_t src_reg, src_next;
    logic        ready;

    assign ready         = (state_reg == ST_IDLE);
    assign s_axis_tready = ready;

    always_comb begin
        state_next    = state_reg;
        src_next      = src_reg;
        cmd           = '0;
        cmd.accept    = s_axis_tvalid & ready;
        cmd.src       = src_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept && stat.is_query) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_INDEX;
            end
            ST_INDEX: begin
                cmd.index = 1'b1;
                priority if (stat.empty) begin
                    src_next   = SRC_ZERO;
                    state_next = ST_FINISH;
                end else if (!stat.mode_svd) begin
                    src_next   = SRC_DENSE;
                    state_next = ST_DREAD;
                end else if (stat.rank_zero) begin
                    src_next   = SRC_ZERO;
                    state_next = ST_FINISH;
                end else begin
                    src_next   = SRC_ACC;
                    state_next = ST_RUN;
                end
            end
            ST_DREAD: begin
                cmd.dense_rd = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_RUN: begin
                cmd.svd_issue = 1'b1;
                if (stat.last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            src_reg   <= SRC_ZERO;
        end else begin
            state_reg <= state_next;
            src_reg   <= src_next;
        end
    end

endmodule

/* sv/lrgs_dp.sv */
// ----------------------------------------------------------------------------
// lrgs_dp
// Datapath: configuration registers, sample and factor stores, coordinate
// clamp, address generation, rank-term multiply pipeline, saturating
// accumulator and output register.
// ----------------------------------------------------------------------------
module lrgs_dp
    import lrgs_pkg::*;
#(
    parameter int MAX_DIM     = DEF_MAX_DIM,
    parameter int MAX_RANK    = DEF_MAX_RANK,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [S_TUSER_W-1:0]   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    output logic [M_TUSER_W-1:0]   m_axis_tuser,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat
);

    localparam int VW          = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam int PW          = 2 * VW;
    localparam int DENSE_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int LEFT_DEPTH  = MAX_DIM * MAX_RANK;
    localparam int RIGHT_DEPTH = MAX_RANK * MAX_DIM * MAX_DIM;
    localparam int DAW         = $clog2(DENSE_DEPTH);
    localparam int LAW         = $clog2(LEFT_DEPTH);
    localparam int SAW         = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int RAW         = $clog2(RIGHT_DEPTH);
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int CW          = $clog2(MAX_DIM);
    localparam int D2W         = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int RANK_W      = $clog2(MAX_RANK + 1);
    localparam logic signed [PW:0] HALF = (PW + 1)'(32768);

    function automatic logic [CW-1:0] clamp_coord(input logic [COORD_W-1:0] q,
                                                   input logic [DIM_W-1:0]   n);
        logic [CW-1:0] res;
        if (q[COORD_W-1]) begin
            res = '0;
        end else if ({1'b0, q[COORD_W-2:0]} >= COORD_W'(n)) begin
            res = CW'(n - 1'b1);
        end else begin
            res = CW'(q);
        end
        return res;
    endfunction

    function automatic logic [VW-1:0] sat_vw(input logic [PW+1:0] v);
        logic [PW-VW+2:0] upper;
        logic [VW-1:0]    res;
        upper = v[PW+1:VW-1];
        if ((&upper) || !(|upper)) begin
            res = v[VW-1:0];
        end else if (v[PW+1]) begin
            res = {1'b1, {(VW-1){1'b0}}};
        end else begin
            res = {1'b0, {(VW-1){1'b1}}};
        end
        return res;
    endfunction

    // configuration
    logic                  mode_reg;
    logic [SIZE_W-1:0]     size_x_reg, size_y_reg, size_z_reg;
    logic [RANK_REG_W-1:0] rank_used_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            size_x_reg    <= '0;
            size_y_reg    <= '0;
            size_z_reg    <= '0;
            rank_used_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODE_SVD:  mode_reg      <= cfg_data[0];
                REG_SIZE_X:    size_x_reg    <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Y:    size_y_reg    <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Z:    size_z_reg    <= cfg_data[SIZE_W-1:0];
                REG_RANK_USED: rank_used_reg <= cfg_data[RANK_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic [DIM_W-1:0]  nx, ny, nz;
    logic [RANK_W-1:0] rank;

    assign nx   = (size_x_reg > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(size_x_reg);
    assign ny   = (size_y_reg > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(size_y_reg);
    assign nz   = (size_z_reg > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(size_z_reg);
    assign rank = (rank_used_reg > MAX_RANK) ? RANK_W'(MAX_RANK) : RANK_W'(rank_used_reg);

    // input fields
    logic [CMD_W-1:0]   command;
    logic [INDEX_W-1:0] write_index;
    logic [VW-1:0]      write_value;
    logic               is_write;
    cmd_code_t          cmd_code;

    assign command     = s_axis_tuser[CMD_W-1:0];
    assign cmd_code    = cmd_code_t'(command);
    assign write_index = s_axis_tdata[WIDX_LSB +: INDEX_W];
    assign write_value = s_axis_tdata[WVAL_LSB +: VW];
    assign is_write    = cmd.accept;

    logic we_dense, we_left, we_sing, we_right;

    always_comb begin
        we_dense = 1'b0;
        we_left  = 1'b0;
        we_sing  = 1'b0;
        we_right = 1'b0;
        unique case (cmd_code)
            CMD_WR_DENSE: we_dense = is_write && (32'(write_index) < 32'(DENSE_DEPTH));
            CMD_WR_LEFT:  we_left  = is_write && (32'(write_index) < 32'(LEFT_DEPTH));
            CMD_WR_SING:  we_sing  = is_write && (32'(write_index) < 32'(MAX_RANK));
            CMD_WR_RIGHT: we_right = is_write && (32'(write_index) < 32'(RIGHT_DEPTH));
            default: begin
            end
        endcase
    end

    // query coordinates
    logic [COORD_W-1:0] qx_reg, qy_reg, qz_reg;
    logic [CW-1:0]      x_reg, y_reg, z_reg;
    logic [D2W-1:0]     col_reg, cols_reg, plane_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            qx_reg <= s_axis_tdata[QX_LSB +: COORD_W];
            qy_reg <= s_axis_tdata[QY_LSB +: COORD_W];
            qz_reg <= s_axis_tdata[QZ_LSB +: COORD_W];
        end
        if (cmd.clamp) begin
            x_reg <= clamp_coord(qx_reg, nx);
            y_reg <= clamp_coord(qy_reg, ny);
            z_reg <= clamp_coord(qz_reg, nz);
        end
        if (cmd.index) begin
            col_reg   <= D2W'(y_reg) * D2W'(nz) + D2W'(z_reg);
            cols_reg  <= D2W'(ny) * D2W'(nz);
            plane_reg <= D2W'(y_reg) + D2W'(ny) * D2W'(z_reg);
        end
    end

    // rank counter
    logic [RANK_W-1:0] r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_reg <= '0;
        end else if (cmd.index) begin
            r_reg <= '0;
        end else if (cmd.svd_issue) begin
            r_reg <= r_reg + 1'b1;
        end
    end

    logic [DAW-1:0] dense_raddr;
    logic [LAW-1:0] left_raddr;
    logic [SAW-1:0] sing_raddr;
    logic [RAW-1:0] right_raddr;

    assign dense_raddr = DAW'(x_reg) + DAW'(nx) * DAW'(plane_reg);
    assign left_raddr  = LAW'(x_reg) * LAW'(rank) + LAW'(r_reg);
    assign sing_raddr  = SAW'(r_reg);
    assign right_raddr = RAW'(r_reg) * RAW'(cols_reg) + RAW'(col_reg);

    logic [VW-1:0] dense_rdata, left_rdata, sing_rdata, right_rdata;

    lrgs_ram #(.WIDTH(VW), .DEPTH(DENSE_DEPTH)) u_dense_ram (
        .aclk  (aclk),
        .we    (we_dense),
        .waddr (DAW'(write_index)),
        .wdata (write_value),
        .re    (cmd.dense_rd),
        .raddr (dense_raddr),
        .rdata (dense_rdata)
    );

    lrgs_ram #(.WIDTH(VW), .DEPTH(LEFT_DEPTH)) u_left_ram (
        .aclk  (aclk),
        .we    (we_left),
        .waddr (LAW'(write_index)),
        .wdata (write_value),
        .re    (cmd.svd_issue),
        .raddr (left_raddr),
        .rdata (left_rdata)
    );

    lrgs_ram #(.WIDTH(VW), .DEPTH(MAX_RANK)) u_sing_ram (
        .aclk  (aclk),
        .we    (we_sing),
        .waddr (SAW'(write_index)),
        .wdata (write_value),
        .re    (cmd.svd_issue),
        .raddr (sing_raddr),
        .rdata (sing_rdata)
    );

    lrgs_ram #(.WIDTH(VW), .DEPTH(RIGHT_DEPTH)) u_right_ram (
        .aclk  (aclk),
        .we    (we_right),
        .waddr (RAW'(write_index)),
        .wdata (write_value),
        .re    (cmd.svd_issue),
        .raddr (right_raddr),
        .rdata (right_rdata)
    );

    // rank-term pipeline
    logic                 v_rd_reg, v_m1_reg, v_p_reg, v_m2_reg, v_t_reg;
    logic signed [PW-1:0] prod1_reg, prod2_reg;
    logic [VW-1:0]        vt1_reg, vt2_reg, p_reg, acc_reg;
    logic signed [PW:0]   term_reg;
    logic signed [PW:0]   rnd1_sum, rnd1, rnd2_sum;
    logic [PW+1:0]        acc_sum;

    assign rnd1_sum = {prod1_reg[PW-1], prod1_reg} + HALF;
    assign rnd1     = rnd1_sum >>> 16;
    assign rnd2_sum = {prod2_reg[PW-1], prod2_reg} + HALF;
    assign acc_sum  = {{(PW+2-VW){acc_reg[VW-1]}}, acc_reg} + {term_reg[PW], term_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_rd_reg <= 1'b0;
            v_m1_reg <= 1'b0;
            v_p_reg  <= 1'b0;
            v_m2_reg <= 1'b0;
            v_t_reg  <= 1'b0;
        end else begin
            v_rd_reg <= cmd.svd_issue;
            v_m1_reg <= v_rd_reg;
            v_p_reg  <= v_m1_reg;
            v_m2_reg <= v_p_reg;
            v_t_reg  <= v_m2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod1_reg <= $signed(left_rdata) * $signed(sing_rdata);
        vt1_reg   <= right_rdata;
        p_reg     <= sat_vw({rnd1[PW], rnd1});
        vt2_reg   <= vt1_reg;
        prod2_reg <= $signed(p_reg) * $signed(vt2_reg);
        term_reg  <= rnd2_sum >>> 16;
        if (cmd.index) begin
            acc_reg <= '0;
        end else if (v_t_reg) begin
            acc_reg <= sat_vw(acc_sum);
        end
    end

    // output register
    logic                   m_valid_reg;
    logic [M_TDATA_W-1:0]   m_data_reg;
    logic [M_TUSER_W-1:0]   m_user_reg;
    logic signed [VW-1:0]   sel_value;
    logic                   sel_status;

    always_comb begin
        unique case (cmd.src)
            SRC_DENSE: begin
                sel_value  = dense_rdata;
                sel_status = 1'b0;
            end
            SRC_ACC: begin
                sel_value  = acc_reg;
                sel_status = 1'b0;
            end
            default: begin
                sel_value  = '0;
                sel_status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg <= M_TDATA_W'(sel_value);
            m_user_reg <= M_TUSER_W'(sel_status);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    assign stat.is_query   = (cmd_code == CMD_QUERY);
    assign stat.empty      = (nx == '0) || (ny == '0) || (nz == '0);
    assign stat.mode_svd   = mode_reg;
    assign stat.rank_zero  = (rank == '0);
    assign stat.last_issue = (r_reg == rank - 1'b1);
    assign stat.pipe_busy  = v_rd_reg | v_m1_reg | v_p_reg | v_m2_reg | v_t_reg;
    assign stat.out_free   = !m_valid_reg || m_axis_tready;

endmodule

/* sv/low_rank_grid_sample_lookup.sv */
// ----------------------------------------------------------------------------
// low_rank_grid_sample_lookup
// Grid sample lookup from a dense store or a truncated SVD of the grid.
// Writes are accepted back to back while idle and produce no result.
// A dense query steps through clamp, index and dense read before its result
// goes to the output register; an SVD query runs the serial rank loop through
// the two-multiplier pipeline and waits for the pipeline to drain first.
// An empty grid or zero rank gives zero with the status bit set. One query is
// in flight at a time; a held result stalls the next query in its last step.
// Reset clears configuration registers to zero; stores stay unwritten.
// ----------------------------------------------------------------------------
module low_rank_grid_sample_lookup
    import lrgs_pkg::*;
#(
    parameter int MAX_DIM     = DEF_MAX_DIM,
    parameter int MAX_RANK    = DEF_MAX_RANK,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // write_index, write_value, query_x, query_y, query_z, zero pad
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // command
    input  logic [S_TUSER_W-1:0]   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // sample_value
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    // status
    output logic [M_TUSER_W-1:0]   m_axis_tuser
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lrgs_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    lrgs_dp #(
        .MAX_DIM     (MAX_DIM),
        .MAX_RANK    (MAX_RANK),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule
